// ===== design/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types, constants and the FNV-1a step for the linear probe hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam int          MAX_IDX_W = 16;

    typedef enum logic [1:0] {
        OP_HAS = 2'd0,
        OP_GET = 2'd1,
        OP_SET = 2'd2,
        OP_RSV = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key;
        logic [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [7:0]  slot;
        logic [31:0] value_out;
        logic        table_full;
    } t_rsp;

    // One hashed request passed from the front end to the probe engine.
    typedef struct packed {
        logic [1:0]           op;
        logic [63:0]          key;
        logic [31:0]          value;
        logic [MAX_IDX_W-1:0] start;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE
    } t_back_state;

    // The FNV prime is 2^40 + 0x1B3, so the product is a short sum of shifts.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== design/lph_ram.sv =====
// ----------------------------------------------------------------------------
// lph_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/lph_front.sv =====
// ----------------------------------------------------------------------------
// lph_front
// Accepts requests, hashes the key one byte per cycle and reduces the hash
// to a start slot, eight bits per cycle when the slot count is not a power
// of two.
// ----------------------------------------------------------------------------
module lph_front #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BYTES   = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lph_pkg::t_req i_req,
    input  logic          i_hold,
    output logic          o_busy,
    input  logic          i_q_full,
    output logic          o_push,
    output lph_pkg::t_job o_job
);
    import lph_pkg::*;

    localparam int  IDXW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int  KBITS = 8 * KEY_BYTES;
    localparam int  BCW   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam bit  POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam logic [BCW-1:0]  LAST_BYTE = BCW'(KEY_BYTES - 1);
    localparam logic [IDXW:0]   SLOTS_EXT = (IDXW+1)'(TABLE_SLOTS);

    t_front_state r_state, n_state;
    logic [1:0]      r_op;
    logic [63:0]     r_key, r_ksh, n_ksh;
    logic [31:0]     r_val;
    logic [63:0]     r_hash, n_hash;
    logic [BCW-1:0]  r_bcnt, n_bcnt;
    logic [2:0]      r_mcnt, n_mcnt;
    logic [IDXW-1:0] r_rem, n_rem;
    logic [IDXW:0]   mod_acc;
    logic [63:0]     hash_step;

    assign hash_step = fnv_step(r_hash, r_ksh[7:0]);

    // Eight restoring steps of hash mod TABLE_SLOTS, top hash bits first.
    always_comb begin
        mod_acc = {1'b0, r_rem};
        for (int i = 0; i < 8; i++) begin
            mod_acc = {mod_acc[IDXW-1:0], r_hash[63-i]};
            if (mod_acc >= SLOTS_EXT) begin
                mod_acc = mod_acc - SLOTS_EXT;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_ksh   = r_ksh;
        n_hash  = r_hash;
        n_bcnt  = r_bcnt;
        n_mcnt  = r_mcnt;
        n_rem   = r_rem;
        unique case (r_state)
            F_IDLE: begin
                if (i_start && !i_hold) begin
                    n_state = F_HASH;
                    n_ksh   = 64'(i_req.key[KBITS-1:0]);
                    n_hash  = FNV_BASIS;
                    n_bcnt  = '0;
                end
            end
            F_HASH: begin
                n_hash = hash_step;
                n_ksh  = r_ksh >> 8;
                n_bcnt = r_bcnt + 1'b1;
                if (r_bcnt == LAST_BYTE) begin
                    n_rem  = '0;
                    n_mcnt = '0;
                    if (POW2) begin
                        n_rem   = hash_step[IDXW-1:0];
                        n_state = F_PUSH;
                    end else begin
                        n_state = F_MOD;
                    end
                end
            end
            F_MOD: begin
                n_rem  = mod_acc[IDXW-1:0];
                n_hash = r_hash << 8;
                n_mcnt = r_mcnt + 1'b1;
                if (r_mcnt == 3'd7) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_ksh  <= n_ksh;
        r_hash <= n_hash;
        r_bcnt <= n_bcnt;
        r_mcnt <= n_mcnt;
        r_rem  <= n_rem;
        if (r_state == F_IDLE && i_start && !i_hold) begin
            r_op  <= i_req.operation;
            r_key <= 64'(i_req.key[KBITS-1:0]);
            r_val <= i_req.value_in;
        end
    end

    always_comb begin
        o_busy      = (r_state != F_IDLE);
        o_push      = (r_state == F_PUSH) && !i_q_full;
        o_job.op    = r_op;
        o_job.key   = r_key;
        o_job.value = r_val;
        o_job.start = MAX_IDX_W'(r_rem);
    end
endmodule

// ===== design/lph_queue.sv =====
// ----------------------------------------------------------------------------
// lph_queue
// Two-entry queue of hashed items between the front end and the probe engine.
// ----------------------------------------------------------------------------
module lph_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lph_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lph_pkg::t_job o_job
);
    import lph_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rptr];
endmodule

// ===== design/lph_back.sv =====
// ----------------------------------------------------------------------------
// lph_back
// Probe engine: clears the table after reset, then walks slots one per cycle
// from the start slot, updates the table on set and issues the result.
// ----------------------------------------------------------------------------
module lph_back #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BITS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  lph_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_strobe,
    output lph_pkg::t_rsp o_rsp
);
    import lph_pkg::*;

    localparam int IDXW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int KBITS = 8 * KEY_BYTES;
    localparam int SVW   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int RW    = 1 + KBITS + SVW;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_SLOTS - 1);

    t_back_state r_state, n_state;
    logic [IDXW-1:0]  r_idx, n_idx, r_cnt, n_cnt, r_start;
    logic [1:0]       r_op;
    logic [KBITS-1:0] r_key;
    logic [SVW-1:0]   r_val;
    logic             r_strobe, n_strobe;
    t_rsp             r_rsp, n_rsp;

    logic             we;
    logic [IDXW-1:0]  waddr, raddr, idx_next;
    logic [RW-1:0]    wdata, rdata;
    logic             e_used, e_match, stop;
    logic [KBITS-1:0] e_key;
    logic [SVW-1:0]   e_val;

    lph_ram #(.WIDTH(RW), .DEPTH(1 << IDXW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign e_used   = rdata[RW-1];
    assign e_key    = rdata[RW-2 -: KBITS];
    assign e_val    = rdata[SVW-1:0];
    assign e_match  = e_used && (e_key == r_key);
    assign stop     = !e_used || e_match;
    assign idx_next = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        unique case (r_state)
            B_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_q_valid) begin
                    n_state = B_PROBE;
                    n_idx   = i_job.start[IDXW-1:0];
                    n_cnt   = '0;
                end
            end
            B_PROBE: begin
                if (stop || r_cnt == LAST_IDX) begin
                    n_state = B_IDLE;
                end else begin
                    n_idx = idx_next;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Memory port, queue pop and the result for the probe that stops or that finds the table full.
    always_comb begin
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = {1'b1, r_key, r_val};
        raddr    = idx_next;
        o_pop    = 1'b0;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        unique case (r_state)
            B_CLEAR: begin
                we    = 1'b1;
                wdata = '0;
            end
            B_IDLE: begin
                raddr = i_job.start[IDXW-1:0];
                o_pop = i_q_valid;
            end
            B_PROBE: begin
                if (stop) begin
                    we                = (r_op == OP_SET);
                    n_strobe          = 1'b1;
                    n_rsp.found       = e_match;
                    n_rsp.slot        = 8'(MAX_IDX_W'(r_idx));
                    n_rsp.value_out   = (r_op == OP_GET && e_match) ? 32'(e_val) : 32'd0;
                    n_rsp.table_full  = 1'b0;
                end else if (r_cnt == LAST_IDX) begin
                    n_strobe          = 1'b1;
                    n_rsp.found       = 1'b0;
                    n_rsp.slot        = 8'(MAX_IDX_W'(r_start));
                    n_rsp.value_out   = 32'd0;
                    n_rsp.table_full  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
        r_cnt <= n_cnt;
        r_rsp <= n_rsp;
        if (o_pop) begin
            r_op    <= i_job.op;
            r_key   <= i_job.key[KBITS-1:0];
            r_val   <= i_job.value[SVW-1:0];
            r_start <= i_job.start[IDXW-1:0];
        end
    end

    assign o_clearing = (r_state == B_CLEAR);
    assign o_strobe   = r_strobe;
    assign o_rsp      = r_rsp;
endmodule

// ===== design/linear_probe_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with FNV-1a 64 hashing and linear probing.
// ----------------------------------------------------------------------------
// After reset the table is cleared one slot per cycle, with busy high. A
// request is taken when start is high and busy low. The front end hashes the
// key at one byte per cycle, then reduces the hash to a start slot when
// TABLE_SLOTS is not a power of two, and hands the item to a two-entry queue,
// waiting while the queue is full; busy covers that time. The probe engine
// reads one slot per cycle from the single table memory, up to TABLE_SLOTS
// slots for an item on a full table. Each result appears for one cycle with
// o_strobe high and cannot be held off; results come out in request order.
module linear_probe_hash_table_unit #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BITS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lph_pkg::t_req i_req,
    output logic          o_strobe,
    output lph_pkg::t_rsp o_rsp
);
    import lph_pkg::*;

    logic q_full, q_push, q_pop, q_valid, front_busy, clearing;
    t_job push_job, head_job;

    lph_front #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BYTES(KEY_BYTES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_hold   (clearing),
        .o_busy   (front_busy),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    lph_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    lph_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (head_job),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_strobe   (o_strobe),
        .o_rsp      (o_rsp)
    );

    assign busy = front_busy || clearing;
endmodule

// ===== verif/linear_probe_hash_table_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit_test
// Drives has, get, set and reserved-opcode requests into the hash table and checks every
// response against a behavioral table with FNV-1a hashing and linear probing.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit_test;
    import lph_pkg::*;

    localparam int SLOTS     = 256;
    localparam int WATCHDOG  = 20000;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_strobe;
    t_rsp  o_rsp;

    linear_probe_hash_table_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Behavioral copy of the table.
    logic        tbl_used  [SLOTS];
    logic [63:0] tbl_key   [SLOTS];
    logic [31:0] tbl_value [SLOTS];

    t_rsp rsp_queue[$];
    int   errors;
    int   idle_pct;
    int   quiet_cycles;
    logic [63:0] known_keys[$];

    function automatic logic [63:0] fnv1a64(input logic [63:0] k);
        logic [63:0] h;
        h = 64'hCBF29CE484222325;
        for (int i = 0; i < 8; i++) begin
            h = h ^ {56'd0, k[8*i +: 8]};
            h = h * 64'h00000100000001B3;
        end
        return h;
    endfunction

    function automatic t_rsp lookup_and_update(input t_req r);
        t_rsp o;
        int   first;
        int   idx;
        logic stopped;
        logic hit;
        first   = int'(fnv1a64(r.key) % SLOTS);
        idx     = first;
        stopped = 1'b0;
        hit     = 1'b0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!tbl_used[idx]) begin
                stopped = 1'b1;
                break;
            end
            if (tbl_key[idx] == r.key) begin
                stopped = 1'b1;
                hit = 1'b1;
                break;
            end
            idx = (idx + 1) % SLOTS;
        end
        if (!stopped) idx = first;
        o = '0;
        if (stopped) begin
            if (t_op'(r.operation) == OP_GET && hit) begin
                o.value_out = tbl_value[idx];
            end else if (t_op'(r.operation) == OP_SET) begin
                if (!hit) begin
                    tbl_key[idx]  = r.key;
                    tbl_used[idx] = 1'b1;
                end
                tbl_value[idx] = r.value_in;
            end
        end
        o.found      = hit;
        o.slot       = idx[7:0];
        o.table_full = !stopped;
        return o;
    endfunction

    // Checks each response as it leaves the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (rsp_queue.size() == 0) begin
                $display("%0t: unexpected response %p", $time, o_rsp);
                errors++;
            end else begin
                t_rsp e;
                e = rsp_queue.pop_front();
                if (o_rsp !== e) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, o_rsp);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("linear_probe_hash_table_unit_test: done, errors");
            $finish;
        end
    end

    // Start stays high from one item to the next unless the sender idles, so
    // it is lowered only at the falling edges spent idling.
    task automatic send_request(input t_op op, input logic [63:0] k, input logic [31:0] v);
        t_req r;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        r.operation = op;
        r.key       = k;
        r.value_in  = v;
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        rsp_queue.push_back(lookup_and_update(r));
        if (op == OP_SET) known_keys.push_back(k);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_request(OP_GET, 64'h0, 32'h0);
        send_request(OP_HAS, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_SET, 64'h0, 32'hFFFF_FFFF);
        send_request(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_request(OP_GET, 64'h0, 32'h0);
        send_request(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234);
        send_request(OP_SET, 64'h0, 32'hA5A5_5A5A);
        send_request(OP_GET, 64'h0, 32'h0);
        send_request(OP_RSV, 64'h0, 32'h1);
        send_request(OP_RSV, 64'h1234_5678_9ABC_DEF0, 32'h1);
        send_request(OP_HAS, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_request(OP_GET, 64'h5555_AAAA_5555_AAAA, 32'h0);
    endtask

    task automatic test_random(input int count);
        logic [63:0] k;
        for (int i = 0; i < count; i++) begin
            if (known_keys.size() > 0 && $urandom_range(99) < 60)
                k = known_keys[$urandom_range(known_keys.size() - 1)];
            else
                k = {$urandom, $urandom};
            send_request(t_op'($urandom_range(3)), k, $urandom);
        end
    endtask

    // Fills every slot, then probes a full table with random new keys and with keys already set.
    task automatic test_full_table();
        int used;
        used = 0;
        for (int s = 0; s < SLOTS; s++) used += tbl_used[s];
        while (used < SLOTS) begin
            send_request(OP_SET, {$urandom, $urandom}, $urandom);
            used = 0;
            for (int s = 0; s < SLOTS; s++) used += tbl_used[s];
        end
        for (int i = 0; i < 12; i++)
            send_request(t_op'($urandom_range(3)), {$urandom, $urandom}, $urandom);
        for (int i = 0; i < 20; i++)
            send_request(t_op'($urandom_range(3)),
                         known_keys[$urandom_range(known_keys.size() - 1)], $urandom);
    endtask

    initial begin
        errors       = 0;
        idle_pct     = 0;
        quiet_cycles = 0;
        start        = 1'b0;
        i_req        = '0;
        i_rst_n      = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            tbl_used[s]  = 1'b0;
            tbl_key[s]   = '0;
            tbl_value[s] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(200);
        idle_pct = 69;
        test_random(150);
        idle_pct = 31;
        test_random(150);
        idle_pct = 0;
        test_full_table();
        idle_pct = 69;
        test_random(100);
        start <= 1'b0;

        while (rsp_queue.size() > 0) @(posedge i_clk);
        repeat (SLOTS + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("linear_probe_hash_table_unit_test: done, clean");
        end else begin
            $display("linear_probe_hash_table_unit_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lph_pkg.sv
design/lph_ram.sv
design/lph_front.sv
design/lph_queue.sv
design/lph_back.sv
design/linear_probe_hash_table_unit.sv
verif/linear_probe_hash_table_unit_test.sv
